/* hdl/sudiv_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sudiv_pkg: shared definitions for the signed/unsigned integer divider
// Operation codes, the per-beat control group and sizing constants used by
// the front end, the queue and the bit pipeline.
// ----------------------------------------------------------------------------
package sudiv_pkg;

  // Default operand width of the divider.
  localparam int unsigned WIDTH_DEF = 32;

  // Depth of the queue between the front end and the bit pipeline.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Operation selected by the mode field.
  typedef enum logic [1:0] {
    MODE_UQUO = 2'd0,
    MODE_UREM = 2'd1,
    MODE_SQUO = 2'd2,
    MODE_SREM = 2'd3
  } mode_e;

  // Control that travels with each operation down the pipeline.
  typedef struct packed {
    logic want_rem;  // deliver the remainder rather than the quotient
    logic negate;    // two's complement negate the picked value
    logic clr_msb;   // clear the top bit (signed quotient on divide by zero)
    logic dbz;       // divisor was zero
  } ctl_t;

endpackage
`default_nettype wire

/* hdl/sudiv_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sudiv_front: command acceptance and operand classification
// Takes a beat, forms the operand magnitudes and the control group, and
// holds the classified beat until the queue takes it.
// ----------------------------------------------------------------------------
module sudiv_front #(
  parameter int unsigned WIDTH = sudiv_pkg::WIDTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output      logic               busy,
  input  wire sudiv_pkg::mode_e   mode_i,
  input  wire logic [WIDTH-1:0]   dividend_i,
  input  wire logic [WIDTH-1:0]   divisor_i,
  input  wire logic               q_full_i,
  output      logic               push_o,
  output      logic [WIDTH-1:0]   a_o,
  output      logic [WIDTH-1:0]   b_o,
  output      sudiv_pkg::ctl_t    ctl_o
);
  import sudiv_pkg::*;

  logic             vld_q, vld_d;
  logic [WIDTH-1:0] a_q, a_d;
  logic [WIDTH-1:0] b_q, b_d;
  ctl_t             ctl_q, ctl_d;
  logic             accept;
  logic             is_signed;
  logic             want_rem;
  logic             n_neg;
  logic             d_neg;
  logic             dbz;

  assign push_o = vld_q & ~q_full_i;
  assign busy   = vld_q & q_full_i;
  assign accept = start & ~busy;

  assign is_signed = (mode_i == MODE_SQUO) || (mode_i == MODE_SREM);
  assign want_rem  = (mode_i == MODE_UREM) || (mode_i == MODE_SREM);
  assign n_neg     = is_signed & dividend_i[WIDTH-1];
  assign d_neg     = is_signed & divisor_i[WIDTH-1];
  assign dbz       = (divisor_i == '0);

  // A zero divisor runs through the pipeline with the raw dividend: every
  // quotient bit comes out set and the remainder ends equal to the dividend.
  always_comb begin
    ctl_d.want_rem = want_rem;
    ctl_d.dbz      = dbz;
    if (dbz) begin
      a_d           = dividend_i;
      b_d           = '0;
      ctl_d.negate  = 1'b0;
      ctl_d.clr_msb = is_signed & ~want_rem;
    end else begin
      a_d           = n_neg ? (~dividend_i) + WIDTH'(1) : dividend_i;
      b_d           = d_neg ? (~divisor_i) + WIDTH'(1) : divisor_i;
      ctl_d.negate  = want_rem ? n_neg : (n_neg ^ d_neg);
      ctl_d.clr_msb = 1'b0;
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (push_o) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_q   <= a_d;
      b_q   <= b_d;
      ctl_q <= ctl_d;
    end
  end

  assign a_o   = a_q;
  assign b_o   = b_q;
  assign ctl_o = ctl_q;

endmodule
`default_nettype wire

/* hdl/sudiv_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sudiv_queue: short queue between front end and bit pipeline
// A small circular buffer of classified beats with full and valid flags.
// ----------------------------------------------------------------------------
module sudiv_queue #(
  parameter int unsigned WIDTH = sudiv_pkg::WIDTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire logic [WIDTH-1:0]   a_i,
  input  wire logic [WIDTH-1:0]   b_i,
  input  wire sudiv_pkg::ctl_t    ctl_i,
  output      logic               full_o,
  output      logic               vld_o,
  input  wire logic               pop_i,
  output      logic [WIDTH-1:0]   a_o,
  output      logic [WIDTH-1:0]   b_o,
  output      sudiv_pkg::ctl_t    ctl_o
);
  import sudiv_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] a_mem   [QUEUE_DEPTH];
  logic [WIDTH-1:0] b_mem   [QUEUE_DEPTH];
  ctl_t             ctl_mem [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (cnt_q == CntW'(QUEUE_DEPTH));
  assign vld_o   = (cnt_q != '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & vld_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      a_mem[wr_ptr_q]   <= a_i;
      b_mem[wr_ptr_q]   <= b_i;
      ctl_mem[wr_ptr_q] <= ctl_i;
    end
  end

  assign a_o   = a_mem[rd_ptr_q];
  assign b_o   = b_mem[rd_ptr_q];
  assign ctl_o = ctl_mem[rd_ptr_q];

endmodule
`default_nettype wire

/* hdl/sudiv_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sudiv_back: restoring division bit pipeline
// One stage per quotient bit, most significant first, then a stage that
// picks quotient or remainder and applies the sign fix-up.
// ----------------------------------------------------------------------------
module sudiv_back #(
  parameter int unsigned WIDTH = sudiv_pkg::WIDTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_vld_i,
  input  wire logic [WIDTH-1:0]   a_i,
  input  wire logic [WIDTH-1:0]   b_i,
  input  wire sudiv_pkg::ctl_t    ctl_i,
  output      logic               valid_o,
  output      logic [WIDTH-1:0]   result_o,
  output      logic               div_by_zero_o
);
  import sudiv_pkg::*;

  // Per-stage registers. The dividend bits shift out of the top of nq_q
  // while the quotient bits shift in at the bottom.
  logic [WIDTH-1:0] rem_q [WIDTH];
  logic [WIDTH-1:0] nq_q  [WIDTH];
  logic [WIDTH-1:0] b_q   [WIDTH];
  ctl_t             ctl_q [WIDTH];
  logic [WIDTH-1:0] vld_q;

  for (genvar k = 0; k < WIDTH; k++) begin : g_stage
    logic [WIDTH-1:0] in_rem;
    logic [WIDTH-1:0] in_nq;
    logic [WIDTH-1:0] in_b;
    ctl_t             in_ctl;
    logic             in_vld;
    logic [WIDTH-1:0] sh;
    logic [WIDTH:0]   diff;
    logic             take;

    if (k == 0) begin : g_first
      assign in_rem = '0;
      assign in_nq  = a_i;
      assign in_b   = b_i;
      assign in_ctl = ctl_i;
      assign in_vld = in_vld_i;
    end else begin : g_next
      assign in_rem = rem_q[k-1];
      assign in_nq  = nq_q[k-1];
      assign in_b   = b_q[k-1];
      assign in_ctl = ctl_q[k-1];
      assign in_vld = vld_q[k-1];
    end

    // The bit shifted out of the partial remainder counts as 2^WIDTH, so
    // the subtraction is taken whenever it is set.
    assign sh   = {in_rem[WIDTH-2:0], in_nq[WIDTH-1]};
    assign diff = {1'b0, sh} - {1'b0, in_b};
    assign take = in_rem[WIDTH-1] | ~diff[WIDTH];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= in_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= take ? diff[WIDTH-1:0] : sh;
      nq_q[k]  <= {in_nq[WIDTH-2:0], take};
      b_q[k]   <= in_b;
      ctl_q[k] <= in_ctl;
    end
  end

  logic [WIDTH-1:0] pick;
  logic [WIDTH-1:0] fixed;
  logic             out_vld_q;
  logic [WIDTH-1:0] result_q;
  logic             dbz_q;

  always_comb begin
    pick = ctl_q[WIDTH-1].want_rem ? rem_q[WIDTH-1] : nq_q[WIDTH-1];
    if (ctl_q[WIDTH-1].clr_msb) begin
      pick[WIDTH-1] = 1'b0;
    end
    fixed = ctl_q[WIDTH-1].negate ? (~pick) + WIDTH'(1) : pick;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= vld_q[WIDTH-1];
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= fixed;
    dbz_q    <= ctl_q[WIDTH-1].dbz;
  end

  assign valid_o       = out_vld_q;
  assign result_o      = result_q;
  assign div_by_zero_o = out_vld_q & dbz_q;

endmodule
`default_nettype wire

/* hdl/signed_unsigned_int_divider.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// signed_unsigned_int_divider: pipelined signed/unsigned integer divider
// Returns the unsigned or signed quotient or remainder of two WIDTH-bit
// operands by restoring division, one pipeline stage per quotient bit.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake               Payload
//   command   in         start high, busy low    mode_i, dividend_i, divisor_i
//   result    out        valid_o strobe          result_o, div_by_zero_o
//
// One command beat is taken every clock cycle while busy is low. It passes
// through the front-end register, the queue, one pipeline stage per
// quotient bit and one stage for the quotient/remainder pick and sign
// fix-up before its result strobe rises. The receiver cannot stall, so the
// pipeline always advances and busy stays low in steady use; it rises only
// if the queue ever fills.
// Reset clears the valid bits of every stage; no clearing pass is needed.
//
// The front end negates negative operands in signed modes and records which
// sign fix-up the result needs. A zero divisor is sent down the pipeline
// with a zero divisor and the raw dividend: the quotient then comes out all
// ones and the remainder equals the dividend, so only the signed quotient
// needs its top bit cleared to give the largest positive value. The most
// negative value divided by minus one wraps to itself through the same path.
// ----------------------------------------------------------------------------
module signed_unsigned_int_divider #(
  parameter int unsigned WIDTH = sudiv_pkg::WIDTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output      logic               busy,
  input  wire logic [1:0]         mode_i,
  input  wire logic [WIDTH-1:0]   dividend_i,
  input  wire logic [WIDTH-1:0]   divisor_i,
  output      logic               valid_o,
  output      logic [WIDTH-1:0]   result_o,
  output      logic               div_by_zero_o
);
  import sudiv_pkg::*;

  // Front end to queue.
  logic             push;
  logic             q_full;
  logic [WIDTH-1:0] f_a;
  logic [WIDTH-1:0] f_b;
  ctl_t             f_ctl;

  // Queue to bit pipeline.
  logic             q_vld;
  logic [WIDTH-1:0] q_a;
  logic [WIDTH-1:0] q_b;
  ctl_t             q_ctl;

  sudiv_front #(
    .WIDTH(WIDTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .mode_i    (mode_e'(mode_i)),
    .dividend_i(dividend_i),
    .divisor_i (divisor_i),
    .q_full_i  (q_full),
    .push_o    (push),
    .a_o       (f_a),
    .b_o       (f_b),
    .ctl_o     (f_ctl)
  );

  // The bit pipeline takes a beat every cycle, so the queue drains whenever
  // it holds anything.
  sudiv_queue #(
    .WIDTH(WIDTH)
  ) u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .a_i   (f_a),
    .b_i   (f_b),
    .ctl_i (f_ctl),
    .full_o(q_full),
    .vld_o (q_vld),
    .pop_i (q_vld),
    .a_o   (q_a),
    .b_o   (q_b),
    .ctl_o (q_ctl)
  );

  sudiv_back #(
    .WIDTH(WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_vld_i     (q_vld),
    .a_i          (q_a),
    .b_i          (q_b),
    .ctl_i        (q_ctl),
    .valid_o      (valid_o),
    .result_o     (result_o),
    .div_by_zero_o(div_by_zero_o)
  );

  // With a pipeline that never stalls the queue never fills up.
  a_never_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy)
    else $error("divider busy although the bit pipeline drains every cycle");

  // A queued beat always leaves the queue in the cycle it is seen.
  a_queue_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_vld |=> !q_full)
    else $error("divider queue filled up");

  // The divide-by-zero flag is only ever raised together with a result.
  a_dbz_with_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_by_zero_o |-> valid_o)
    else $error("divide-by-zero flag raised without a result beat");

endmodule
`default_nettype wire
